/* rtl/core/srkt_pkg.sv */
// Shared constants, types and codes for the sorted reference-counted key table.
package srkt_pkg;

    localparam int CAPACITY   = 64;
    localparam int COUNT_BITS = 16;
    localparam int KEY_W      = 64;
    localparam int USED_W     = $clog2(CAPACITY + 1);

    // Result field widths on the stream port
    localparam int EV_W       = 3;
    localparam int RC_W       = 16;
    localparam int EU_W       = 7;
    localparam int OUT_DATA_W = 32;
    localparam int OUT_PAD_W  = OUT_DATA_W - EV_W - RC_W - EU_W;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

    localparam logic [EV_W-1:0] EV_INC      = 3'd0;
    localparam logic [EV_W-1:0] EV_FIRST    = 3'd1;
    localparam logic [EV_W-1:0] EV_DEC      = 3'd2;
    localparam logic [EV_W-1:0] EV_LAST     = 3'd3;
    localparam logic [EV_W-1:0] EV_NOTFOUND = 3'd4;
    localparam logic [EV_W-1:0] EV_FULL     = 3'd5;
    localparam logic [EV_W-1:0] EV_SAT      = 3'd6;

    localparam logic KIND_ACQUIRE = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_RES,
        ST_APPLY
    } t_state;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_INS,
        OP_REM,
        OP_INC,
        OP_DEC
    } t_op;

    // Broadcast from the controller to every cell
    typedef struct packed {
        logic              cmp;
        t_op               op;
        logic [KEY_W-1:0]  key;
    } t_cell_cmd;

    // Contents of one cell, handed to the neighbors
    typedef struct packed {
        logic                  valid;
        logic [KEY_W-1:0]      key;
        logic [COUNT_BITS-1:0] count;
    } t_cell_data;

endpackage

/* rtl/core/srkt_cell.sv */
// One table slot: holds a key and its count, compares against the broadcast key, shifts.
module srkt_cell
    import srkt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cell_cmd             i_cmd,
    input  t_cell_data            i_left,
    input  logic                  i_left_lt,
    input  t_cell_data            i_right,
    output t_cell_data            o_data,
    output logic                  o_lt,
    output logic                  o_eq,
    output logic [COUNT_BITS-1:0] o_hit_count
);

    logic                  r_valid;
    logic [KEY_W-1:0]      r_key;
    logic [COUNT_BITS-1:0] r_count;
    logic                  r_lt;
    logic                  r_eq;
    logic [COUNT_BITS-1:0] r_hit_count;

    logic                  n_valid;
    logic [KEY_W-1:0]      n_key;
    logic [COUNT_BITS-1:0] n_count;
    logic                  cmp_lt;
    logic                  cmp_eq;

    assign cmp_lt = r_valid && ($signed(r_key) < $signed(i_cmd.key));
    assign cmp_eq = r_valid && (r_key == i_cmd.key);

    always_comb begin
        n_valid = r_valid;
        n_key   = r_key;
        n_count = r_count;
        case (i_cmd.op)
            OP_INS: begin
                if (!r_lt) begin
                    if (i_left_lt) begin
                        // first slot not below the key: new entry lands here
                        n_valid = 1'b1;
                        n_key   = i_cmd.key;
                        n_count = COUNT_ONE;
                    end else begin
                        n_valid = i_left.valid;
                        n_key   = i_left.key;
                        n_count = i_left.count;
                    end
                end
            end
            OP_REM: begin
                if (!r_lt) begin
                    n_valid = i_right.valid;
                    n_key   = i_right.key;
                    n_count = i_right.count;
                end
            end
            OP_INC: begin
                if (r_eq) begin
                    n_count = r_count + COUNT_ONE;
                end
            end
            OP_DEC: begin
                if (r_eq) begin
                    n_count = r_count - COUNT_ONE;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_lt    <= 1'b0;
            r_eq    <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (i_cmd.cmp) begin
                r_lt <= cmp_lt;
                r_eq <= cmp_eq;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_count <= n_count;
        if (i_cmd.cmp) begin
            r_hit_count <= cmp_eq ? r_count : '0;
        end
    end

    assign o_data.valid = r_valid;
    assign o_data.key   = r_key;
    assign o_data.count = r_count;
    assign o_lt         = r_lt;
    assign o_eq         = r_eq;
    assign o_hit_count  = r_hit_count;

endmodule

/* rtl/core/srkt_ctrl.sv */
// Sequencer: takes an item, runs compare, resolve and apply, and holds the result beat.
module srkt_ctrl
    import srkt_pkg::*;
(
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_kind,
    input  logic [KEY_W-1:0]                    i_key,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [OUT_DATA_W-1:0]               o_out_data,
    output t_cell_cmd                           o_cmd,
    input  logic [CAPACITY-1:0]                 i_eq,
    input  logic [CAPACITY-1:0][COUNT_BITS-1:0] i_hit_count
);

    t_state                r_state, n_state;
    logic                  r_kind;
    logic [KEY_W-1:0]      r_key;
    t_op                   r_op, n_op;
    logic [EV_W-1:0]       r_ev, n_ev;
    logic [COUNT_BITS-1:0] r_cnt, n_cnt;
    logic [USED_W-1:0]     r_used, n_used;
    logic [USED_W-1:0]     r_res_used;
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic                  accept;
    logic                  slot_free;
    logic                  hit;
    logic [COUNT_BITS-1:0] hit_count;

    assign slot_free = !r_out_valid || i_out_ready;
    assign accept    = i_in_valid && o_in_ready;

    always_comb begin
        hit       = 1'b0;
        hit_count = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            hit       = hit | i_eq[i];
            hit_count = hit_count | i_hit_count[i];
        end
    end

    // Decide the table operation and the result from the registered flags
    always_comb begin
        n_op   = OP_HOLD;
        n_ev   = EV_NOTFOUND;
        n_cnt  = '0;
        n_used = r_used;
        if (r_kind == KIND_ACQUIRE) begin
            if (!hit) begin
                if (r_used == USED_W'(CAPACITY)) begin
                    n_ev = EV_FULL;
                end else begin
                    n_op   = OP_INS;
                    n_ev   = EV_FIRST;
                    n_cnt  = COUNT_ONE;
                    n_used = r_used + USED_W'(1);
                end
            end else if (hit_count == COUNT_MAX) begin
                n_ev  = EV_SAT;
                n_cnt = hit_count;
            end else begin
                n_op  = OP_INC;
                n_cnt = hit_count + COUNT_ONE;
                n_ev  = (hit_count == '0) ? EV_FIRST : EV_INC;
            end
        end else begin
            if (!hit) begin
                n_ev = EV_NOTFOUND;
            end else if (hit_count <= COUNT_ONE) begin
                n_op   = OP_REM;
                n_ev   = EV_LAST;
                n_used = r_used - USED_W'(1);
            end else begin
                n_op  = OP_DEC;
                n_ev  = EV_DEC;
                n_cnt = hit_count - COUNT_ONE;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_in_valid) n_state = ST_CMP;
            ST_CMP:   n_state = ST_RES;
            ST_RES:   n_state = ST_APPLY;
            ST_APPLY: if (slot_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd.cmp  = 1'b0;
        o_cmd.op   = OP_HOLD;
        o_cmd.key  = r_key;
        unique case (r_state)
            ST_IDLE:  o_in_ready = 1'b1;
            ST_CMP:   o_cmd.cmp = 1'b1;
            ST_RES:   o_cmd.op = OP_HOLD;
            ST_APPLY: if (slot_free) o_cmd.op = r_op;
            default:  o_in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_APPLY && slot_free) begin
                r_used      <= r_res_used;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= i_kind;
            r_key  <= i_key;
        end
        if (r_state == ST_RES) begin
            r_op       <= n_op;
            r_ev       <= n_ev;
            r_cnt      <= n_cnt;
            r_res_used <= n_used;
        end
        if (r_state == ST_APPLY && slot_free) begin
            r_out_data <= {{OUT_PAD_W{1'b0}}, EU_W'(r_res_used), RC_W'(r_cnt), r_ev};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

/* rtl/core/sorted_refcount_key_table_top.sv */
// Top level: controller plus the row of key cells, with stream ports.
//
// Sorted reference-counted key table. Holds up to 64 signed 64-bit keys in
// ascending order, each with a 16-bit reference count. Send kind=0 on tuser to
// acquire a key and kind=1 to release it; every beat in returns one beat out
// with the event code, the count after the operation and the number of keys
// held. Each item goes through these steps in order: the key is registered on
// acceptance, every cell compares against it, the cells' flags are combined
// into an operation, and each cell keeps its entry, takes its neighbor's
// (insert or remove) or adjusts its count. The result beat is registered at
// the end of the apply step, and the controller then returns to idle to take
// the next item. A new item is taken once the previous one has moved to the
// output register, so a waiting result stalls input only while that register
// is still full.
module sorted_refcount_key_table_top
    import srkt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [KEY_W-1:0]      s_axis_tdata,  // [63:0] key
    input  logic [0:0]            s_axis_tuser,  // [0] kind
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata   // [2:0] event_res, [18:3] ref_count,
                                                 // [25:19] entries_used, [31:26] zero
);

    t_cell_cmd                           cmd;
    t_cell_data                          cell_data [CAPACITY];
    logic [CAPACITY-1:0]                 cell_lt;
    logic [CAPACITY-1:0]                 cell_eq;
    logic [CAPACITY-1:0][COUNT_BITS-1:0] cell_hit_count;
    t_cell_data                          empty_data;

    assign empty_data = '0;

    srkt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_kind      (s_axis_tuser[0]),
        .i_key       (s_axis_tdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .o_cmd       (cmd),
        .i_eq        (cell_eq),
        .i_hit_count (cell_hit_count)
    );

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_cell_data left_data;
        t_cell_data right_data;
        logic       left_lt;

        if (g == 0) begin : g_first
            // nothing sits left of slot zero: it is the insert point unless below
            assign left_data = empty_data;
            assign left_lt   = 1'b1;
        end else begin : g_mid
            assign left_data = cell_data[g-1];
            assign left_lt   = cell_lt[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign right_data = empty_data;
        end else begin : g_inner
            assign right_data = cell_data[g+1];
        end

        srkt_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (cmd),
            .i_left      (left_data),
            .i_left_lt   (left_lt),
            .i_right     (right_data),
            .o_data      (cell_data[g]),
            .o_lt        (cell_lt[g]),
            .o_eq        (cell_eq[g]),
            .o_hit_count (cell_hit_count[g])
        );
    end

endmodule

/* test/sorted_refcount_key_table_top_test.sv */
// Testbench for the sorted reference-counted key table: directed table and random traffic.
`timescale 1ns / 100ps

module sorted_refcount_key_table_top_test;
    import srkt_pkg::*;

    localparam logic KIND_RELEASE = ~KIND_ACQUIRE;
    localparam logic [KEY_W-1:0] KEY_MIN = 64'h8000_0000_0000_0000;
    localparam logic [KEY_W-1:0] KEY_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam int POOL_SIZE = 96;
    localparam int N_ROWS    = 20;
    localparam int N_SEGS    = 4;

    typedef struct packed {
        logic [EV_W-1:0] ev;
        logic [RC_W-1:0] cnt;
        logic [EU_W-1:0] used;
    } t_outcome;

    typedef struct packed {
        logic             kind;
        logic [KEY_W-1:0] key;
        logic             typed;
        t_outcome         want;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [KEY_W-1:0]      s_axis_tdata = '0;   // [63:0] key
    logic [0:0]            s_axis_tuser = '0;   // [0] kind
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // [2:0] event_res, [18:3] ref_count,
                                                // [25:19] entries_used, [31:26] zero

    // Shadow of the table contents
    logic signed [KEY_W-1:0] held_keys [CAPACITY];
    logic [COUNT_BITS-1:0]   held_counts [CAPACITY];
    int                      held_used = 0;

    t_outcome         pending_outcomes [$];
    logic [KEY_W-1:0] key_pool [POOL_SIZE];
    bit               idle_on = 1'b1;
    int               fail_count = 0;
    int               stall_left = 0;

    // Rows with typed = 0 take their expectation from the shadow table.
    t_row directed_rows [0:N_ROWS-1] = '{
        '{KIND_RELEASE, 64'd0,          1'b1, '{EV_NOTFOUND, 16'd0, 7'd0}},
        '{KIND_ACQUIRE, KEY_MIN,        1'b1, '{EV_FIRST,    16'd1, 7'd1}},
        '{KIND_ACQUIRE, KEY_MAX,        1'b1, '{EV_FIRST,    16'd1, 7'd2}},
        '{KIND_ACQUIRE, 64'd0,          1'b1, '{EV_FIRST,    16'd1, 7'd3}},
        '{KIND_ACQUIRE, {KEY_W{1'b1}},  1'b1, '{EV_FIRST,    16'd1, 7'd4}},
        '{KIND_ACQUIRE, KEY_MAX,        1'b1, '{EV_INC,      16'd2, 7'd4}},
        '{KIND_ACQUIRE, 64'd1,          1'b1, '{EV_FIRST,    16'd1, 7'd5}},
        '{KIND_RELEASE, KEY_MAX,        1'b1, '{EV_DEC,      16'd1, 7'd5}},
        '{KIND_RELEASE, KEY_MIN,        1'b1, '{EV_LAST,     16'd0, 7'd4}},
        '{KIND_RELEASE, 64'd5,          1'b1, '{EV_NOTFOUND, 16'd0, 7'd4}},
        '{KIND_RELEASE, {KEY_W{1'b1}},  1'b1, '{EV_LAST,     16'd0, 7'd3}},
        '{KIND_ACQUIRE, {32{2'b01}},    1'b0, '0},
        '{KIND_ACQUIRE, {32{2'b10}},    1'b0, '0},
        '{KIND_ACQUIRE, KEY_MIN + 64'd1, 1'b0, '0},
        '{KIND_ACQUIRE, KEY_MAX - 64'd1, 1'b0, '0},
        '{KIND_RELEASE, 64'd0,          1'b0, '0},
        '{KIND_RELEASE, KEY_MAX,        1'b0, '0},
        '{KIND_ACQUIRE, 64'd0,          1'b0, '0},
        '{KIND_RELEASE, {32{2'b10}},    1'b0, '0},
        '{KIND_RELEASE, KEY_MIN + 64'd1, 1'b0, '0}
    };

    sorted_refcount_key_table_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 i_clk = ~i_clk;

    // Apply one acquire or release to the shadow table and return what it reports.
    function automatic t_outcome table_apply(input logic kind, input logic signed [KEY_W-1:0] key);
        int       pos;
        bit       hit;
        t_outcome res;
        pos = 0;
        while (pos < held_used && held_keys[pos] < key)
            pos++;
        hit = (pos < held_used) && (held_keys[pos] == key);
        res.cnt = '0;
        if (kind == KIND_ACQUIRE) begin
            if (!hit) begin
                if (held_used >= CAPACITY) begin
                    res.ev = EV_FULL;
                end else begin
                    for (int i = held_used; i > pos; i--) begin
                        held_keys[i]   = held_keys[i-1];
                        held_counts[i] = held_counts[i-1];
                    end
                    held_keys[pos]   = key;
                    held_counts[pos] = COUNT_ONE;
                    held_used++;
                    res.cnt = 16'd1;
                    res.ev  = EV_FIRST;
                end
            end else if (held_counts[pos] == COUNT_MAX) begin
                res.cnt = held_counts[pos];
                res.ev  = EV_SAT;
            end else begin
                held_counts[pos] = held_counts[pos] + 1'b1;
                res.cnt = held_counts[pos];
                res.ev  = (held_counts[pos] == COUNT_ONE) ? EV_FIRST : EV_INC;
            end
        end else begin
            if (!hit) begin
                res.ev = EV_NOTFOUND;
            end else if (held_counts[pos] <= COUNT_ONE) begin
                // remove and close up the tail
                for (int i = pos; i < held_used - 1; i++) begin
                    held_keys[i]   = held_keys[i+1];
                    held_counts[i] = held_counts[i+1];
                end
                held_used--;
                res.ev = EV_LAST;
            end else begin
                held_counts[pos] = held_counts[pos] - 1'b1;
                res.cnt = held_counts[pos];
                res.ev  = EV_DEC;
            end
        end
        res.used = EU_W'(held_used);
        return res;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [KEY_W-1:0] pick_key(input logic kind);
        int roll;
        roll = $urandom_range(0, 99);
        if (held_used > 0 && roll < ((kind == KIND_ACQUIRE) ? 10 : 60))
            return held_keys[$urandom_range(0, held_used - 1)];
        if (roll < 85)
            return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        return {$urandom, $urandom};
    endfunction

    // Drive one beat and hold it until accepted, then record its expectation.
    task automatic send_item(input logic kind, input logic [KEY_W-1:0] key,
                             input logic typed, input t_outcome want);
        int       gap;
        t_outcome predicted;
        gap = 0;
        if (idle_on && $urandom_range(0, 99) < 35)
            gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= key;
        s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = table_apply(kind, key);
        pending_outcomes.push_back(typed ? want : predicted);
    endtask

    // Stop sending and hold until every result is back.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_outcomes.size() != 0);
    endtask

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            fail_count++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    // Random stalls on the result side
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 99) < 20) begin
            stall_left <= pick_gap() - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_outcomes.size() == 0) begin
                fail_count++;
                $error("result beat with no expectation: %h", m_axis_tdata);
            end else begin
                want = pending_outcomes.pop_front();
                check_field("event_res", 32'(want.ev), 32'(m_axis_tdata[2:0]));
                check_field("ref_count", 32'(want.cnt), 32'(m_axis_tdata[18:3]));
                check_field("entries_used", 32'(want.used), 32'(m_axis_tdata[25:19]));
                check_field("pad", 32'd0, 32'(m_axis_tdata[31:26]));
            end
        end
    end

    initial begin
        #60ms;
        $display("sorted_refcount_key_table_top_test: FAIL");
        $finish;
    end

    initial begin
        int               seg_len [N_SEGS];
        int               acq_pct [N_SEGS];
        logic             kind;
        logic [KEY_W-1:0] key;

        seg_len = '{180, 100, 100, 60};
        acq_pct = '{90, 20, 85, 10};

        // Extremes, sign-boundary neighbors and close clusters, then random keys
        key_pool[0] = KEY_MIN;
        key_pool[1] = KEY_MAX;
        key_pool[2] = '0;
        key_pool[3] = {KEY_W{1'b1}};
        key_pool[4] = 64'd1;
        key_pool[5] = KEY_MIN + 64'd1;
        key_pool[6] = KEY_MAX - 64'd1;
        key_pool[7] = 64'hFFFF_FFFF_FFFF_FFFE;
        for (int i = 8; i < 24; i++)
            key_pool[i] = 64'h0000_0001_0000_0000 + 64'(i);
        for (int i = 24; i < POOL_SIZE; i++)
            key_pool[i] = {$urandom, $urandom};

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < N_ROWS; r++)
            send_item(directed_rows[r].kind, directed_rows[r].key,
                      directed_rows[r].typed, directed_rows[r].want);
        drain();

        // Alternate filling and draining the table; the third segment runs without idling
        for (int s = 0; s < N_SEGS; s++) begin
            idle_on = (s != 2);
            for (int n = 0; n < seg_len[s]; n++) begin
                kind = ($urandom_range(0, 99) < acq_pct[s]) ? KIND_ACQUIRE : KIND_RELEASE;
                key  = pick_key(kind);
                send_item(kind, key, 1'b0, '0);
            end
            drain();
        end

        repeat (10) @(posedge i_clk);
        if (fail_count == 0)
            $display("sorted_refcount_key_table_top_test: PASS");
        else
            $display("sorted_refcount_key_table_top_test: FAIL");
        $finish;
    end

endmodule
